// File: rtl/core/wav_riff_header_parser_defines.svh
// Assertion macros shared by the WAV header parser RTL.
// No dependencies.
`ifndef WAV_RIFF_HEADER_PARSER_DEFINES_SVH
`define WAV_RIFF_HEADER_PARSER_DEFINES_SVH

// implication checked every cycle outside reset
`define WRHP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication checked in the cycle after the antecedent
`define WRHP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/wrhp_pkg.sv
// Package for the WAV header parser: phase codes, kinds, status codes, tags.
// No dependencies.
`default_nettype none
package wrhp_pkg;
   localparam int unsigned CfgWidth = 33;

   typedef enum logic [17:0] {
      PH_RIFF  = 18'h00001, PH_SIZE  = 18'h00002, PH_WAVE  = 18'h00004,
      PH_FMT   = 18'h00008, PH_FMTLEN = 18'h00010, PH_TAG  = 18'h00020,
      PH_CHAN  = 18'h00040, PH_RATE  = 18'h00080, PH_BRATE = 18'h00100,
      PH_ALIGN = 18'h00200, PH_BITS  = 18'h00400, PH_EXTLEN = 18'h00800,
      PH_EXT   = 18'h01000, PH_NAME  = 18'h02000, PH_CSIZE = 18'h04000,
      PH_SKIP  = 18'h08000, PH_DSIZE = 18'h10000, PH_DATA  = 18'h20000
   } phase_type;

   localparam logic [1:0] KIND_DATA   = 2'd0;
   localparam logic [1:0] KIND_EXT    = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_HDR     = 3'd1;
   localparam logic [2:0] ST_UNSUP   = 3'd2;
   localparam logic [2:0] ST_EXTRACT = 3'd3;
   localparam logic [2:0] ST_DATA    = 3'd4;
   localparam logic [2:0] ST_FMT     = 3'd5;

   localparam logic [31:0] TAG_RIFF = 32'h46464952;
   localparam logic [31:0] TAG_WAVE = 32'h45564157;
   localparam logic [31:0] TAG_FMT  = 32'h20746D66;
   localparam logic [31:0] TAG_DATA = 32'h61746164;
   localparam logic [15:0] PCM_TAG  = 16'h0001;
   localparam logic [15:0] CH_MONO  = 16'h0001;
   localparam logic [15:0] CH_STEREO = 16'h0002;
   localparam logic [31:0] MIN_FMT_LEN = 32'd16;

   // one queued result item
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  payload_byte;
      logic [2:0]  status;
      logic [1:0]  channel_count;
      logic [31:0] sample_rate;
      logic [31:0] byte_rate;
      logic [15:0] block_align;
      logic [15:0] sample_bits;
      logic        run_last;
   } rsp_type;

   function automatic logic name_char_ok(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A) || c == 8'h20;
   endfunction
endpackage
`default_nettype wire

// File: rtl/core/wav_riff_header_parser.sv
// WAV header parser: one byte per cycle while req_stall is low. Each accepted item is parsed in the
// accept cycle; its 0..2 results are registered in a 4-entry queue before they appear.
// Throughput: one item per cycle while the queue holds two free entries.
// Synchronous active-high reset clears parse state, file_length and queue.
`default_nettype none
module wav_riff_header_parser
   import wrhp_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_write_enable,
   input  wire logic [CfgWidth-1:0] csr_write_data,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [7:0]          req_byte_value,
   input  wire logic                req_end_of_file,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [1:0]               rsp_kind,
   output logic [7:0]               rsp_payload_byte,
   output logic [2:0]               rsp_status,
   output logic [1:0]               rsp_channel_count,
   output logic [31:0]              rsp_sample_rate,
   output logic [31:0]              rsp_byte_rate,
   output logic [15:0]              rsp_block_align,
   output logic [15:0]              rsp_sample_bits,
   output logic                     rsp_run_last
);
`include "wav_riff_header_parser_defines.svh"

   logic [CfgWidth-1:0] file_length_ff;
   phase_type   phase_ff, phase_in;
   logic [1:0]  fcnt_ff, fcnt_in;
   logic [31:0] shift_ff, shift_in;
   logic [31:0] remain_ff, remain_in;
   logic [31:0] fmtlen_ff, fmtlen_in;
   logic [15:0] chan_ff, chan_in;
   logic [31:0] rate_ff, rate_in;
   logic [31:0] brate_ff, brate_in;
   logic [15:0] align_ff, align_in;
   logic [15:0] bits_ff, bits_in;
   logic        fin_ff, fin_in;

   logic        room, accept;
   logic [31:0] acc, v;
   logic        done2, done4, done;
   logic        byte_out, st_out;
   logic [1:0]  byte_kind;
   logic [2:0]  st_code;
   rsp_type     r0, r1, qo;
   logic        push0, push1;

   assign req_stall = !room;
   assign accept    = req_valid && room;

   assign acc   = shift_ff | ({24'b0, req_byte_value} << {fcnt_ff, 3'b000});
   assign v     = acc;
   assign done2 = fcnt_ff == 2'd1;
   assign done4 = fcnt_ff == 2'd3;

   always_comb begin
      phase_in  = phase_ff;
      fcnt_in   = fcnt_ff + 2'd1;
      shift_in  = acc;
      remain_in = remain_ff;
      fmtlen_in = fmtlen_ff;
      chan_in   = chan_ff;
      rate_in   = rate_ff;
      brate_in  = brate_ff;
      align_in  = align_ff;
      bits_in   = bits_ff;
      fin_in    = fin_ff;
      byte_out  = 1'b0;
      byte_kind = KIND_DATA;
      st_out    = 1'b0;
      st_code   = ST_OK;
      done      = 1'b0;
      case (phase_ff)
         PH_TAG, PH_CHAN, PH_ALIGN, PH_BITS, PH_EXTLEN: done = done2;
         PH_EXT, PH_SKIP, PH_DATA: done = 1'b0;
         default: done = done4;
      endcase
      if (done) begin
         fcnt_in  = '0;
         shift_in = '0;
      end
      if (phase_ff == PH_EXT || phase_ff == PH_SKIP || phase_ff == PH_DATA) begin
         fcnt_in  = fcnt_ff;
         shift_in = shift_ff;
      end
      if (!fin_ff) begin
         case (phase_ff)
            PH_RIFF: if (done) begin
               if (v != TAG_RIFF) begin st_out = 1'b1; st_code = ST_HDR; end
               else phase_in = PH_SIZE;
            end
            PH_SIZE: if (done) begin
               if ({1'b0, v} + 33'd8 != file_length_ff) begin
                  st_out = 1'b1; st_code = ST_DATA;
               end else phase_in = PH_WAVE;
            end
            PH_WAVE: if (done) begin
               if (v != TAG_WAVE) begin st_out = 1'b1; st_code = ST_HDR; end
               else phase_in = PH_FMT;
            end
            PH_FMT: if (done) begin
               if (v != TAG_FMT) begin st_out = 1'b1; st_code = ST_HDR; end
               else phase_in = PH_FMTLEN;
            end
            PH_FMTLEN: if (done) begin
               fmtlen_in = v;
               if (v < MIN_FMT_LEN) begin st_out = 1'b1; st_code = ST_FMT; end
               else phase_in = PH_TAG;
            end
            PH_TAG: if (done) begin
               if (v[15:0] != PCM_TAG) begin st_out = 1'b1; st_code = ST_UNSUP; end
               else phase_in = PH_CHAN;
            end
            PH_CHAN: if (done) begin
               chan_in = v[15:0];
               if (v[15:0] != CH_MONO && v[15:0] != CH_STEREO) begin
                  st_out = 1'b1; st_code = ST_FMT;
               end else phase_in = PH_RATE;
            end
            PH_RATE: if (done) begin
               rate_in = v;
               if (v == '0) begin st_out = 1'b1; st_code = ST_FMT; end
               else phase_in = PH_BRATE;
            end
            PH_BRATE: if (done) begin
               brate_in = v;
               phase_in = PH_ALIGN;
            end
            PH_ALIGN: if (done) begin
               align_in = v[15:0];
               phase_in = PH_BITS;
            end
            PH_BITS: if (done) begin
               bits_in = v[15:0];
               phase_in = (fmtlen_ff > MIN_FMT_LEN) ? PH_EXTLEN : PH_NAME;
            end
            PH_EXTLEN: if (done) begin
               remain_in = {16'b0, v[15:0]};
               phase_in  = (v[15:0] != '0) ? PH_EXT : PH_NAME;
            end
            PH_EXT: begin
               byte_out  = 1'b1;
               byte_kind = KIND_EXT;
               remain_in = remain_ff - 32'd1;
               if (remain_ff == 32'd1) phase_in = PH_NAME;
            end
            PH_NAME: if (done) begin
               if (!name_char_ok(v[7:0]) || !name_char_ok(v[15:8]) ||
                   !name_char_ok(v[23:16]) || !name_char_ok(v[31:24])) begin
                  st_out = 1'b1; st_code = ST_EXTRACT;
               end else phase_in = (v == TAG_DATA) ? PH_DSIZE : PH_CSIZE;
            end
            PH_CSIZE: if (done) begin
               remain_in = v;
               phase_in  = (v != '0) ? PH_SKIP : PH_NAME;
            end
            PH_SKIP: begin
               remain_in = remain_ff - 32'd1;
               if (remain_ff == 32'd1) phase_in = PH_NAME;
            end
            PH_DSIZE: if (done) begin
               remain_in = v;
               if (v == '0) begin st_out = 1'b1; st_code = ST_OK; end
               else phase_in = PH_DATA;
            end
            PH_DATA: begin
               byte_out  = 1'b1;
               remain_in = remain_ff - 32'd1;
               if (remain_ff == 32'd1) begin st_out = 1'b1; st_code = ST_OK; end
            end
            default: begin st_out = 1'b1; st_code = ST_EXTRACT; end
         endcase
         if (!st_out && req_end_of_file) begin
            st_out  = 1'b1;
            st_code = ST_EXTRACT;
         end
         if (st_out) fin_in = 1'b1;
      end
   end

   // the byte-rate check needs the full product at the bits field; it is
   // evaluated combinationally below from bits and registered rate*channels
   logic [31:0] rc_ff;       // rate * channels, set once channels/rate known
   logic [31:0] full_expect;
   logic        brate_bad;
   assign full_expect = {3'b0, v[15:3]} * rc_ff;
   assign brate_bad   = brate_ff == '0 || brate_ff != full_expect;

   logic        st_fin;
   logic [2:0]  st_fin_code;
   logic        fin_fin;
   logic [15:0] chan_stat;
   logic [31:0] rate_stat, brate_stat;
   logic [15:0] align_stat, bits_stat;
   always_comb begin
      st_fin      = st_out;
      st_fin_code = st_code;
      fin_fin     = fin_in;
      if (!fin_ff && phase_ff == PH_BITS && done && brate_bad) begin
         st_fin      = 1'b1;
         st_fin_code = ST_FMT;
         fin_fin     = 1'b1;
      end
      chan_stat  = chan_in;
      rate_stat  = rate_in;
      brate_stat = brate_in;
      align_stat = align_in;
      bits_stat  = bits_in;
   end

   always_comb begin
      r0 = '0;
      r1 = '0;
      r0.kind = byte_kind;
      r0.payload_byte = req_byte_value;
      r1.kind = KIND_STATUS;
      r1.status = st_fin_code;
      r1.channel_count = (chan_stat == CH_MONO || chan_stat == CH_STEREO) ?
                         chan_stat[1:0] : 2'd0;
      r1.sample_rate = rate_stat;
      r1.byte_rate   = brate_stat;
      r1.block_align = align_stat;
      r1.sample_bits = bits_stat;
      r1.run_last    = 1'b1;
      r0.run_last    = !st_fin;
      push0 = 1'b0;
      push1 = 1'b0;
      if (accept && byte_out && st_fin) begin
         push0 = 1'b1; push1 = 1'b1;
      end else if (accept && byte_out) begin
         push0 = 1'b1;
      end else if (accept && st_fin) begin
         push0 = 1'b1; r0 = r1;
      end
   end

   wrhp_rsp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push0    (push0),
      .push1    (push1),
      .data0    (r0),
      .data1    (r1),
      .room     (room),
      .out_valid(rsp_valid),
      .out_stall(rsp_stall),
      .out_data (qo)
   );

   assign rsp_kind          = qo.kind;
   assign rsp_payload_byte  = qo.payload_byte;
   assign rsp_status        = qo.status;
   assign rsp_channel_count = qo.channel_count;
   assign rsp_sample_rate   = qo.sample_rate;
   assign rsp_byte_rate     = qo.byte_rate;
   assign rsp_block_align   = qo.block_align;
   assign rsp_sample_bits   = qo.sample_bits;
   assign rsp_run_last      = qo.run_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         file_length_ff <= '0;
      end else if (csr_write_enable) begin
         file_length_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_RIFF;
         fcnt_ff   <= '0;
         shift_ff  <= '0;
         remain_ff <= '0;
         fmtlen_ff <= '0;
         chan_ff   <= '0;
         rate_ff   <= '0;
         brate_ff  <= '0;
         align_ff  <= '0;
         bits_ff   <= '0;
         fin_ff    <= 1'b0;
         rc_ff     <= '0;
      end else if (accept) begin
         if (req_end_of_file) begin
            phase_ff  <= PH_RIFF;
            fcnt_ff   <= '0;
            shift_ff  <= '0;
            remain_ff <= '0;
            fmtlen_ff <= '0;
            chan_ff   <= '0;
            rate_ff   <= '0;
            brate_ff  <= '0;
            align_ff  <= '0;
            bits_ff   <= '0;
            fin_ff    <= 1'b0;
            rc_ff     <= '0;
         end else begin
            phase_ff  <= phase_in;
            fcnt_ff   <= fcnt_in;
            shift_ff  <= shift_in;
            remain_ff <= remain_in;
            fmtlen_ff <= fmtlen_in;
            chan_ff   <= chan_in;
            rate_ff   <= rate_in;
            brate_ff  <= brate_in;
            align_ff  <= align_in;
            bits_ff   <= bits_in;
            fin_ff    <= fin_fin;
            // rate*channels, channels is 1 or 2 here so this is a shift
            if (phase_ff == PH_BRATE) begin
               rc_ff <= (chan_ff == CH_STEREO) ? {rate_ff[30:0], 1'b0} : rate_ff;
            end
         end
      end
   end

   `WRHP_ASSERT_IMPL(a_stall_full, clock, reset, !room, rsp_valid, "stall with empty queue")
   `WRHP_ASSERT_NEXT(a_fin_no_data, clock, reset, accept && fin_ff && !req_end_of_file, !$past(push0), "output after outcome")
   `WRHP_ASSERT_IMPL(a_push_order, clock, reset, push1, push0, "second push without first")
   `WRHP_ASSERT_IMPL(a_onehot, clock, reset, 1'b1, $onehot(phase_ff), "phase not one-hot")
endmodule
`default_nettype wire

// File: rtl/core/wrhp_rsp_queue.sv
// Four-entry result queue decoupling the parser from rsp stall.
// Depends on wrhp_pkg.
`default_nettype none
module wrhp_rsp_queue
   import wrhp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push0,
   input  wire logic    push1,
   input  wire rsp_type data0,
   input  wire rsp_type data1,
   output logic         room,
   output logic         out_valid,
   input  wire logic    out_stall,
   output rsp_type      out_data
);
   rsp_type    mem_ff [4];
   logic [1:0] wr_ff, rd_ff;
   logic [2:0] cnt_ff, cnt_in;
   logic       pop;
   logic [1:0] n_push;

   assign pop       = out_valid && !out_stall;
   assign out_valid = cnt_ff != 3'd0;
   assign out_data  = mem_ff[rd_ff];
   assign room      = cnt_ff <= 3'd2;
   assign n_push    = {1'b0, push0} + {1'b0, push1};
   assign cnt_in    = cnt_ff + {1'b0, n_push} - {2'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_ff + n_push;
         rd_ff  <= rd_ff + {1'b0, pop};
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push0) begin
         mem_ff[wr_ff] <= data0;
      end
      if (push1) begin
         mem_ff[push0 ? wr_ff + 2'd1 : wr_ff] <= data1;
      end
   end
endmodule
`default_nettype wire
